### hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CHK_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### hw/rtl/brle_pkg.sv
// Types and constants of the byte run-length encoder.
// No dependencies.
package brle_pkg;

  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 7;            // packet length field of a header
  localparam int WORD_BYTES = 8;
  localparam int WORD_W     = BYTE_W * WORD_BYTES;
  localparam int FILL_W     = 4;            // 0..8 bytes in a word
  localparam logic [BYTE_W-1:0] RUN_FLAG = 8'h80;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_LIT   = 2'd2
  } pkt_mode_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LIT_APPEND,
    DP_LIT_START,
    DP_RUN_START,
    DP_RUN_INC,
    DP_RUN_HDR,
    DP_RUN_BYTE,
    DP_FL_HDR,
    DP_FL_DATA
  } dp_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAKE,
    ST_RUN_HDR,
    ST_RUN_BYTE,
    ST_FL_HDR,
    ST_FL_DATA,
    ST_END_CHECK,
    ST_FINISH
  } ctl_state_t;

  typedef enum logic [1:0] {
    RET_TAKE,
    RET_NEXT,
    RET_FINISH
  } flush_ret_t;

  typedef struct packed {
    logic   latch;    // capture the input word
    logic   pass;     // 0: held byte vs. new byte, 1: new byte as the final one
    dp_op_t op;
    logic   finish;   // close the burst, update lookahead
  } dp_cmd_t;

  typedef struct packed {
    logic      held_valid;
    logic      eq;
    pkt_mode_t mode;
    logic      lit_room;
    logic      lit_fill;
    logic      run_max;
    logic      lc_zero;
    logic      fl_last;
    logic      cur_end;
    logic      acc_busy;
    logic      put_ok;
    logic      close_ok;
  } dp_status_t;

endpackage

### hw/rtl/brle_in_if.sv
// Input channel of the encoder: one raw byte and its end mark per word.
// Depends on brle_pkg.
interface brle_in_if;
  import brle_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              stream_end;

  modport source (output valid, data_byte, stream_end, input ready);
  modport sink   (input valid, data_byte, stream_end, output ready);
endinterface

### hw/rtl/brle_out_if.sv
// Output channel of the encoder: up to eight packed encoded bytes per word.
// Depends on brle_pkg.
interface brle_out_if;
  import brle_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] packed_bytes;
  logic [FILL_W-1:0] byte_count;
  logic              last_of_burst;
  logic              stream_done;

  modport source (output valid, packed_bytes, byte_count, last_of_burst, stream_done,
                  input ready);
  modport sink   (input valid, packed_bytes, byte_count, last_of_burst, stream_done,
                  output ready);
endinterface

### hw/rtl/brle_datapath.sv
// Encoder datapath: lookahead byte, run/literal counters, literal store,
// byte packer and output register. Depends on brle_pkg.
module brle_datapath #(
  parameter int MAX_PACKET = 127
) (
  input  logic                         clk,
  input  logic                         rst,
  input  brle_pkg::dp_cmd_t            cmd,
  output brle_pkg::dp_status_t         st,
  input  logic [brle_pkg::BYTE_W-1:0]  data_byte,
  input  logic                         stream_end,
  output logic                         pkt_valid,
  input  logic                         pkt_ready,
  output logic [brle_pkg::WORD_W-1:0]  packed_bytes,
  output logic [brle_pkg::FILL_W-1:0]  byte_count,
  output logic                         last_of_burst,
  output logic                         stream_done
);
  import brle_pkg::*;

  localparam int AW = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_PACKET);
  localparam logic [FILL_W-1:0] FULL    = FILL_W'(WORD_BYTES);

  logic [BYTE_W-1:0] cur_byte;
  logic              cur_end;
  logic [BYTE_W-1:0] held_byte;
  logic              held_valid;
  logic [CNT_W-1:0]  run_count;
  logic [CNT_W-1:0]  literal_count;
  logic [CNT_W-1:0]  rd_idx;
  pkt_mode_t         packet_mode;

  logic [BYTE_W-1:0] lit_mem [MAX_PACKET];
  logic [BYTE_W-1:0] rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  logic [WORD_W-1:0] acc_word;
  logic [FILL_W-1:0] acc_cnt;

  logic [BYTE_W-1:0] cur_c;
  logic              put_en;
  logic [BYTE_W-1:0] put_byte;
  logic              push_mid;
  logic              push_fin;
  logic              pkt_free;

  assign cur_c    = cmd.pass ? cur_byte : held_byte;
  assign pkt_free = !pkt_valid || pkt_ready;

  always_comb begin
    st.held_valid = held_valid;
    st.eq         = !cmd.pass && (held_byte == cur_byte);
    st.mode       = packet_mode;
    st.lit_room   = literal_count < MAX_CNT;
    st.lit_fill   = literal_count == MAX_CNT - CNT_W'(1);
    st.run_max    = run_count >= MAX_CNT;
    st.lc_zero    = literal_count == '0;
    st.fl_last    = rd_idx == literal_count;
    st.cur_end    = cur_end;
    st.acc_busy   = acc_cnt != '0;
    st.put_ok     = (acc_cnt != FULL) || pkt_free;
    st.close_ok   = (acc_cnt == '0) || pkt_free;
  end

  // byte emission and store access for the current command
  always_comb begin
    put_en   = 1'b0;
    put_byte = cur_c;
    wr_en    = 1'b0;
    wr_addr  = literal_count[AW-1:0];
    rd_en    = 1'b0;
    rd_addr  = rd_idx[AW-1:0];
    unique case (cmd.op)
      DP_LIT_APPEND: wr_en = 1'b1;
      DP_LIT_START: begin
        wr_en   = 1'b1;
        wr_addr = '0;
      end
      DP_RUN_HDR: begin
        put_en   = 1'b1;
        put_byte = RUN_FLAG | {1'b0, run_count};
      end
      DP_RUN_BYTE: put_en = 1'b1;
      DP_FL_HDR: begin
        put_en   = 1'b1;
        put_byte = {1'b0, literal_count};
        rd_en    = 1'b1;
        rd_addr  = '0;
      end
      DP_FL_DATA: begin
        put_en   = 1'b1;
        put_byte = rd_data;
        rd_en    = !st.fl_last;
      end
      default: ;
    endcase
  end

  assign push_mid = put_en && (acc_cnt == FULL);
  assign push_fin = cmd.finish && (acc_cnt != '0);

  always_ff @(posedge clk) begin
    if (wr_en) lit_mem[wr_addr] <= cur_c;
    if (rd_en) rd_data <= lit_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur_byte <= data_byte;
      cur_end  <= stream_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte     <= '0;
      held_valid    <= 1'b0;
      run_count     <= '0;
      literal_count <= '0;
      rd_idx        <= '0;
      packet_mode   <= MODE_START;
    end else begin
      unique case (cmd.op)
        DP_LIT_APPEND: literal_count <= literal_count + CNT_W'(1);
        DP_LIT_START: begin
          literal_count <= CNT_W'(1);
          packet_mode   <= MODE_LIT;
        end
        DP_RUN_START: begin
          run_count   <= CNT_W'(2);
          packet_mode <= MODE_RUN;
        end
        DP_RUN_INC: run_count <= run_count + CNT_W'(1);
        DP_RUN_BYTE: begin
          run_count     <= '0;
          literal_count <= '0;
          packet_mode   <= MODE_LIT;
        end
        DP_FL_HDR: begin
          rd_idx <= CNT_W'(1);
          if (st.lc_zero) packet_mode <= MODE_START;
        end
        DP_FL_DATA: begin
          if (st.fl_last) begin
            literal_count <= '0;
            packet_mode   <= MODE_START;
          end else begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
        end
        default: ;
      endcase
      if (cmd.finish) begin
        if (cur_end) begin
          held_byte     <= '0;
          held_valid    <= 1'b0;
          run_count     <= '0;
          literal_count <= '0;
          packet_mode   <= MODE_START;
        end else begin
          held_byte  <= cur_byte;
          held_valid <= 1'b1;
        end
      end
    end
  end

  // packer: a full word is pushed only when a ninth byte arrives, so the
  // final word of a burst can still carry its last flag
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_cnt <= '0;
    end else if (put_en) begin
      if (acc_cnt == '0 || acc_cnt == FULL) begin
        acc_word <= WORD_W'(put_byte);
        acc_cnt  <= FILL_W'(1);
      end else begin
        acc_word[{acc_cnt[2:0], 3'b000} +: BYTE_W] <= put_byte;
        acc_cnt <= acc_cnt + FILL_W'(1);
      end
    end else if (push_fin) begin
      acc_cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
    end else if (push_mid || push_fin) begin
      pkt_valid <= 1'b1;
    end else if (pkt_ready) begin
      pkt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid || push_fin) begin
      packed_bytes  <= acc_word;
      byte_count    <= acc_cnt;
      last_of_burst <= push_fin;
      stream_done   <= push_fin && cur_end;
    end
  end

endmodule

### hw/rtl/brle_controller.sv
// Encoder sequencer: walks each input word through packet decisions,
// run and literal emission, and burst close. Depends on brle_pkg.
module brle_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  brle_pkg::dp_status_t  st,
  output brle_pkg::dp_cmd_t     cmd
);
  import brle_pkg::*;

  ctl_state_t state, state_next;
  logic       pass, pass_next;
  flush_ret_t ret, ret_next;

  ctl_state_t done_state;
  logic       done_pass;

  // where a finished byte decision leads
  assign done_state = (!pass && st.cur_end) ? ST_TAKE :
                      (!pass ? ST_FINISH : ST_END_CHECK);
  assign done_pass  = pass | st.cur_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pass  <= 1'b0;
      ret   <= RET_TAKE;
    end else begin
      state <= state_next;
      pass  <= pass_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    pass_next  = pass;
    ret_next   = ret;
    in_ready   = 1'b0;
    cmd.latch  = 1'b0;
    cmd.pass   = pass;
    cmd.op     = DP_NONE;
    cmd.finish = 1'b0;

    unique case (state) inside
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          pass_next  = 1'b0;
          state_next = ST_TAKE;
        end
      end

      ST_TAKE: begin
        state_next = done_state;
        pass_next  = done_pass;
        if (!pass && !st.held_valid) begin
          // nothing held yet: decision is empty
        end else begin
          case (st.mode)
            MODE_LIT: begin
              if (!st.eq && st.lit_room) begin
                cmd.op = DP_LIT_APPEND;
                if (st.lit_fill) begin
                  ret_next   = RET_NEXT;
                  state_next = ST_FL_HDR;
                  pass_next  = pass;
                end
              end else begin
                ret_next   = RET_TAKE;
                state_next = ST_FL_HDR;
                pass_next  = pass;
              end
            end
            MODE_RUN: begin
              if (st.eq && !st.run_max) begin
                cmd.op = DP_RUN_INC;
              end else begin
                state_next = ST_RUN_HDR;
                pass_next  = pass;
              end
            end
            default: begin
              cmd.op = st.eq ? DP_RUN_START : DP_LIT_START;
            end
          endcase
        end
        // quiet word: close right here
        if (state_next == ST_FINISH && !st.acc_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_RUN_HDR: begin
        if (st.put_ok) begin
          cmd.op     = DP_RUN_HDR;
          state_next = ST_RUN_BYTE;
        end
      end

      ST_RUN_BYTE: begin
        if (st.put_ok) begin
          cmd.op     = DP_RUN_BYTE;
          state_next = done_state;
          pass_next  = done_pass;
        end
      end

      ST_FL_HDR, ST_FL_DATA: begin
        if (st.put_ok) begin
          cmd.op = (state == ST_FL_HDR) ? DP_FL_HDR : DP_FL_DATA;
          if ((state == ST_FL_HDR) ? st.lc_zero : st.fl_last) begin
            case (ret)
              RET_TAKE:   state_next = ST_TAKE;
              RET_NEXT: begin
                state_next = done_state;
                pass_next  = done_pass;
              end
              default:    state_next = ST_FINISH;
            endcase
          end else begin
            state_next = ST_FL_DATA;
          end
        end
      end

      ST_END_CHECK: begin
        if (st.mode == MODE_LIT) begin
          ret_next   = RET_FINISH;
          state_next = ST_FL_HDR;
        end else begin
          state_next = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (st.close_ok) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/byte_run_length_encoder.sv
// Channel    Dir  Word contents
// byte_in    in   data_byte[7:0], stream_end
// pkt_out    out  packed_bytes[63:0], byte_count[3:0], last_of_burst, stream_done
//
// A word that completes no packet is accepted and decided, and is closed in the
// decision step when the byte packer is empty. Each encoded byte passes through
// the byte packer; a run packet adds a header and its byte, a literal flush a
// header and one store read per byte, the end word its final take, flush, close.
// Output stalls hold the byte packer once a full word waits; input is taken
// again as soon as the burst is closed. Synchronous reset, no clearing pass.
// Depends on brle_pkg, brle_in_if, brle_out_if, brle_controller, brle_datapath.
module byte_run_length_encoder #(
  parameter int MAX_PACKET = 127
) (
  input  logic        clk,
  input  logic        rst,
  brle_in_if.sink     byte_in,
  brle_out_if.source  pkt_out
);
  import brle_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  brle_controller u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_in.valid),
    .in_ready (byte_in.ready),
    .st       (st),
    .cmd      (cmd)
  );

  brle_datapath #(
    .MAX_PACKET (MAX_PACKET)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .data_byte     (byte_in.data_byte),
    .stream_end    (byte_in.stream_end),
    .pkt_valid     (pkt_out.valid),
    .pkt_ready     (pkt_out.ready),
    .packed_bytes  (pkt_out.packed_bytes),
    .byte_count    (pkt_out.byte_count),
    .last_of_burst (pkt_out.last_of_burst),
    .stream_done   (pkt_out.stream_done)
  );

endmodule

### hw/rtl/brle_checker.sv
// Port-level checks of the encoder, bound to the top level.
// Depends on brle_pkg and assert_macros.svh.
`include "assert_macros.svh"

module brle_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [brle_pkg::FILL_W-1:0]  byte_count,
  input logic                         last_of_burst,
  input logic                         stream_done
);
  import brle_pkg::*;

  `CHK_NOW(a_count_range, clk, rst, out_valid, (byte_count != '0 && byte_count <= FILL_W'(WORD_BYTES)))
  `CHK_NOW(a_done_is_last, clk, rst, out_valid && stream_done, last_of_burst)
  `CHK_NEXT(a_one_word_at_a_time, clk, rst, in_valid && in_ready, !in_ready)
  `CHK_NEXT(a_out_held, clk, rst, out_valid && !out_ready, out_valid)

endmodule

bind byte_run_length_encoder brle_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (byte_in.valid),
  .in_ready      (byte_in.ready),
  .out_valid     (pkt_out.valid),
  .out_ready     (pkt_out.ready),
  .byte_count    (pkt_out.byte_count),
  .last_of_burst (pkt_out.last_of_burst),
  .stream_done   (pkt_out.stream_done)
);
